[rtl/core/maxcut_one_flip_local_search_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the max-cut one-flip local search block
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MAXCUT_ONE_FLIP_LOCAL_SEARCH_ASSERT_SVH
`define MAXCUT_ONE_FLIP_LOCAL_SEARCH_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define MCUT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define MCUT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mcut_pkg.sv]
// ---------------------------------------------------------------------------
// mcut_pkg
// Shared types and constants of the max-cut one-flip local search block.
// ---------------------------------------------------------------------------
package mcut_pkg;

  // Default sizes
  localparam int MCUT_MAX_VERTICES = 256;
  localparam int MCUT_WEIGHT_BITS  = 16;

  // Fixed field widths
  localparam int MCUT_IDX_W     = 8;
  localparam int MCUT_EW_W      = 16;
  localparam int MCUT_VCOUNT_W  = 9;
  localparam int MCUT_CUT_W     = 32;
  localparam int MCUT_SWEEP_W   = 16;
  localparam int MCUT_IN_DATA_W = 40;
  localparam int MCUT_OUT_DATA_W = 56;

  localparam logic [MCUT_VCOUNT_W-1:0] MCUT_VCOUNT_RESET = 9'd256;
  localparam logic [MCUT_SWEEP_W-1:0]  MCUT_SWEEP_MAX    = 16'hFFFF;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_WR_WEIGHT = 2'd0,
    FUNC_WR_SIDE   = 2'd1,
    FUNC_RUN       = 2'd2,
    FUNC_RD_SIDE   = 2'd3
  } mcut_func_e_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_V_START,
    ST_V_LATCH,
    ST_U_LOOP,
    ST_U_DRAIN,
    ST_V_END,
    ST_DONE
  } mcut_state_t;

  // Control of the shared accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
    logic cut_mode;
    logic side_v;
    logic side_u;
    logic u_gt_v;
    logic u_eq_v;
  } mcut_acc_ctl_t;

endpackage

[rtl/core/mcut_ram.sv]
// ---------------------------------------------------------------------------
// mcut_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module mcut_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/mcut_gain_unit.sv]
// ---------------------------------------------------------------------------
// mcut_gain_unit
// Shared add/subtract accumulator for one vertex row: cut share or flip gain.
// ---------------------------------------------------------------------------
module mcut_gain_unit import mcut_pkg::*; #(
  parameter int WEIGHT_BITS = MCUT_WEIGHT_BITS,
  parameter int ACC_BITS    = MCUT_WEIGHT_BITS + 9
) (
  input  logic                       clk,
  input  mcut_acc_ctl_t              ctl,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  output logic signed [ACC_BITS-1:0] acc
);

  logic signed [ACC_BITS-1:0] acc_r;
  logic signed [ACC_BITS-1:0] acc_nxt;
  logic signed [ACC_BITS-1:0] weight_x;
  logic                       use_term;
  logic                       subtract;

  // Pick the term: cross pairs above the diagonal for the cut,
  // same side adds and other side subtracts for the gain
  always_comb begin
    weight_x = ACC_BITS'(weight);
    if (ctl.cut_mode) begin
      use_term = ctl.u_gt_v && (ctl.side_u != ctl.side_v);
      subtract = 1'b0;
    end else begin
      use_term = !ctl.u_eq_v;
      subtract = ctl.side_u != ctl.side_v;
    end
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.valid && use_term) begin
      acc_nxt = subtract ? (acc_r - weight_x) : (acc_r + weight_x);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[rtl/core/maxcut_one_flip_local_search.sv]
// ---------------------------------------------------------------------------
// maxcut_one_flip_local_search
// Max-cut one-flip local search over a stored weight matrix and side bits.
// ---------------------------------------------------------------------------
// Every input transaction gives one result transaction. A run first sums the
// cut over all vertex pairs and then sweeps the vertices until a sweep flips
// nothing; each pass streams the rows of the n active vertices through the
// single read port of the weight memory into one shared accumulator, one
// weight per cycle while a row is streamed. The weight matrix is kept once per
// unordered pair. Memories have no clearing pass: weights and side bits read
// before being written return arbitrary data. The input port is not ready
// while an item is being worked on.
// ---------------------------------------------------------------------------
module maxcut_one_flip_local_search import mcut_pkg::*; #(
  parameter int MAX_VERTICES = MCUT_MAX_VERTICES,
  parameter int WEIGHT_BITS  = MCUT_WEIGHT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration: vertex_count
  input  logic                       cfg_wr_en,
  input  logic [MCUT_VCOUNT_W-1:0]   cfg_wr_data,
  // Input channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // row_vertex[7:0], col_vertex[15:8], edge_weight[31:16], side_in[32], zero fill
  input  logic [MCUT_IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [1:0]                 in_tuser,
  // Result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // side_out[0], cut_value[32:1], sweep_count[48:33], zero fill
  output logic [MCUT_OUT_DATA_W-1:0] out_tdata
);

  localparam int VW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int WDEPTH = 1 << (2 * VW);
  localparam int GW     = WEIGHT_BITS + VW + 1;

  // Input fields
  mcut_func_e_t                 in_func;
  logic [MCUT_IDX_W-1:0]        in_row;
  logic [MCUT_IDX_W-1:0]        in_col;
  logic signed [MCUT_EW_W-1:0]  in_weight;
  logic                         in_side;
  logic                         row_ok;
  logic                         col_ok;
  logic [VW-1:0]                row_idx;
  logic [VW-1:0]                col_idx;

  assign in_func   = mcut_func_e_t'(in_tuser);
  assign in_row    = in_tdata[7:0];
  assign in_col    = in_tdata[15:8];
  assign in_weight = in_tdata[31:16];
  assign in_side   = in_tdata[32];
  assign row_ok    = 32'(in_row) < 32'(MAX_VERTICES);
  assign col_ok    = 32'(in_col) < 32'(MAX_VERTICES);
  assign row_idx   = VW'(in_row);
  assign col_idx   = VW'(in_col);

  // State
  mcut_state_t              state_r, state_nxt;
  logic [MCUT_VCOUNT_W-1:0] vcount_r;
  logic [VW-1:0]            v_r, v_nxt;
  logic [VW-1:0]            u_r, u_nxt;
  logic [VW-1:0]            pu_r;
  logic                     pv_r;
  logic                     side_v_r, side_v_nxt;
  logic                     cut_mode_r, cut_mode_nxt;
  logic                     changed_r, changed_nxt;
  logic [MCUT_CUT_W-1:0]    cut_r, cut_nxt;
  logic [MCUT_SWEEP_W-1:0]  sweeps_r, sweeps_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic                     res_side_r, res_side_nxt;
  logic                     out_valid_r;
  logic                     out_side_r;
  logic [MCUT_CUT_W-1:0]    out_cut_r;
  logic [MCUT_SWEEP_W-1:0]  out_sweeps_r;

  // Memory ports
  logic                          w_we;
  logic [2*VW-1:0]               w_waddr;
  logic signed [WEIGHT_BITS-1:0] w_wdata;
  logic [2*VW-1:0]               w_raddr;
  logic signed [WEIGHT_BITS-1:0] w_rdata;
  logic                          s_we;
  logic [VW-1:0]                 s_waddr;
  logic                          s_wdata;
  logic [VW-1:0]                 s_raddr;
  logic                          s_rdata;

  // Accumulator and output control
  mcut_acc_ctl_t          acc_ctl;
  logic signed [GW-1:0]   acc;
  logic                   gain_pos;
  logic                   load_out;
  logic                   load_side;
  logic                   slot_free;
  logic [CW-1:0]          n_act;
  logic [CW-1:0]          n_last;
  logic                   v_last;
  logic                   u_last;
  logic [VW-1:0]          wr_lo, wr_hi, rd_lo, rd_hi;

  // Clamp the vertex count to 1 .. MAX_VERTICES
  always_comb begin
    if (vcount_r == '0) begin
      n_act = CW'(1);
    end else if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_act = CW'(MAX_VERTICES);
    end else begin
      n_act = CW'(vcount_r);
    end
  end

  assign n_last    = n_act - CW'(1);
  assign v_last    = CW'(v_r) == n_last;
  assign u_last    = CW'(u_r) == n_last;
  assign slot_free = !out_valid_r || out_tready;
  assign gain_pos  = !acc[GW-1] && (acc != '0);

  // One entry per unordered pair: lower index first
  assign wr_lo   = (row_idx < col_idx) ? row_idx : col_idx;
  assign wr_hi   = (row_idx < col_idx) ? col_idx : row_idx;
  assign rd_lo   = (v_r < u_r) ? v_r : u_r;
  assign rd_hi   = (v_r < u_r) ? u_r : v_r;
  assign w_waddr = {wr_lo, wr_hi};
  assign w_raddr = {rd_lo, rd_hi};
  assign w_wdata = WEIGHT_BITS'(in_weight);

  // Drive the shared accumulator from the read pipeline
  assign acc_ctl.clear    = state_r == ST_V_LATCH;
  assign acc_ctl.valid    = pv_r;
  assign acc_ctl.cut_mode = cut_mode_r;
  assign acc_ctl.side_v   = side_v_r;
  assign acc_ctl.side_u   = s_rdata;
  assign acc_ctl.u_gt_v   = pu_r > v_r;
  assign acc_ctl.u_eq_v   = pu_r == v_r;

  mcut_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mcut_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VERTICES)
  ) u_side_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mcut_gain_unit #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ACC_BITS    (GW)
  ) u_gain_unit (
    .clk    (clk),
    .ctl    (acc_ctl),
    .weight (w_rdata),
    .acc    (acc)
  );

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt    = state_r;
    v_nxt        = v_r;
    u_nxt        = u_r;
    side_v_nxt   = side_v_r;
    cut_mode_nxt = cut_mode_r;
    changed_nxt  = changed_r;
    cut_nxt      = cut_r;
    sweeps_nxt   = sweeps_r;
    rd_ok_nxt    = rd_ok_r;
    res_side_nxt = res_side_r;
    w_we         = 1'b0;
    s_we         = 1'b0;
    s_waddr      = row_idx;
    s_wdata      = in_side;
    s_raddr      = v_r;
    load_out     = 1'b0;
    load_side    = 1'b0;
    in_tready    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_func) inside
            FUNC_WR_WEIGHT, FUNC_WR_SIDE: begin
              w_we = (in_func == FUNC_WR_WEIGHT) && row_ok && col_ok;
              s_we = (in_func == FUNC_WR_SIDE) && row_ok;
              res_side_nxt = 1'b0;
              if (slot_free) begin
                load_out = 1'b1;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            FUNC_RUN: begin
              cut_nxt      = '0;
              sweeps_nxt   = '0;
              v_nxt        = '0;
              cut_mode_nxt = 1'b1;
              changed_nxt  = 1'b0;
              state_nxt    = ST_V_START;
            end
            FUNC_RD_SIDE: begin
              s_raddr   = row_idx;
              rd_ok_nxt = row_ok;
              state_nxt = ST_RD;
            end
          endcase
        end
      end

      ST_RD: begin
        res_side_nxt = rd_ok_r && s_rdata;
        state_nxt    = ST_DONE;
      end

      // Fetch this vertex's side bit
      ST_V_START: begin
        s_raddr   = v_r;
        state_nxt = ST_V_LATCH;
      end

      ST_V_LATCH: begin
        side_v_nxt = s_rdata;
        u_nxt      = '0;
        state_nxt  = ST_U_LOOP;
      end

      // Stream the row: one weight and one side bit a cycle
      ST_U_LOOP: begin
        s_raddr = u_r;
        if (u_last) begin
          state_nxt = ST_U_DRAIN;
        end else begin
          u_nxt = u_r + VW'(1);
        end
      end

      ST_U_DRAIN: begin
        state_nxt = ST_V_END;
      end

      // Fold the row result into the cut; flip on positive gain
      ST_V_END: begin
        s_waddr = v_r;
        s_wdata = !side_v_r;
        if (cut_mode_r || gain_pos) begin
          cut_nxt = cut_r + MCUT_CUT_W'(acc);
        end
        if (!cut_mode_r && gain_pos) begin
          s_we        = 1'b1;
          changed_nxt = 1'b1;
        end
        if (!v_last) begin
          v_nxt     = v_r + VW'(1);
          state_nxt = ST_V_START;
        end else if (cut_mode_r) begin
          cut_mode_nxt = 1'b0;
          changed_nxt  = 1'b0;
          v_nxt        = '0;
          state_nxt    = ST_V_START;
        end else begin
          if (sweeps_r != MCUT_SWEEP_MAX) begin
            sweeps_nxt = sweeps_r + MCUT_SWEEP_W'(1);
          end
          if (changed_r || gain_pos) begin
            changed_nxt = 1'b0;
            v_nxt       = '0;
            state_nxt   = ST_V_START;
          end else begin
            res_side_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end
        end
      end

      // Hold the result until the output register frees up
      ST_DONE: begin
        if (slot_free) begin
          load_out  = 1'b1;
          load_side = res_side_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r   <= MCUT_VCOUNT_RESET;
      cut_r      <= '0;
      sweeps_r   <= '0;
      cut_mode_r <= 1'b0;
      changed_r  <= 1'b0;
      pv_r       <= 1'b0;
      v_r        <= '0;
      u_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      cut_r      <= cut_nxt;
      sweeps_r   <= sweeps_nxt;
      cut_mode_r <= cut_mode_nxt;
      changed_r  <= changed_nxt;
      pv_r       <= state_r == ST_U_LOOP;
      v_r        <= v_nxt;
      u_r        <= u_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pu_r       <= u_r;
    side_v_r   <= side_v_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_side_r <= res_side_nxt;
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_side_r   <= load_side;
      out_cut_r    <= cut_r;
      out_sweeps_r <= sweeps_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_sweeps_r, out_cut_r, out_side_r};

  // Checks
  `include "maxcut_one_flip_local_search_assert.svh"

  `MCUT_ASSERT_NOW(a_no_write_in_row, state_r == ST_U_LOOP || state_r == ST_U_DRAIN, !s_we && !w_we, "memory written while a row is streamed")
  `MCUT_ASSERT_NOW(a_no_flip_in_cut_pass, state_r == ST_V_END && s_we, !cut_mode_r, "side bit flipped during the cut pass")
  `MCUT_ASSERT_NOW(a_result_from_idle_or_done, $rose(out_valid_r), $past(state_r) == ST_IDLE || $past(state_r) == ST_DONE, "result loaded outside idle or done")
  `MCUT_ASSERT_NEXT(a_run_start, state_r == ST_IDLE && in_tvalid && in_func == FUNC_RUN, state_r == ST_V_START && cut_mode_r && cut_r == '0, "run did not start with a cleared cut pass")

endmodule

[bench/maxcut_one_flip_local_search_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// maxcut_one_flip_local_search_tb
// Self-checking bench for the max-cut one-flip local search block. A short
// table of directed transactions comes first, then a preload that writes
// every side bit and every weight pair among the first vertices, then random
// phases over small vertex counts. Each phase writes weights and sides, runs
// the search and reads sides back. A predictor of the search, or a typed
// expectation from the directed table, supplies the expected result of every
// accepted transaction, and results are checked in order.
// ---------------------------------------------------------------------------
module maxcut_one_flip_local_search_tb;
  import mcut_pkg::*;

  localparam int NV           = MCUT_MAX_VERTICES;
  localparam int PRELOAD_N    = 24;
  localparam int RANDOM_ITEMS = 740;
  localparam int CALM_FROM    = 640;
  // Slowest search is a 24-vertex run
  localparam int STALL_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic        side;
    logic [31:0] cut;
    logic [15:0] sweeps;
  } cut_result_t;

  typedef struct packed {
    mcut_func_e_t func;
    logic [7:0]   row_v;
    logic [7:0]   col_v;
    logic [15:0]  weight;
    logic         side;
  } search_item_t;

  typedef enum bit {STEP_CFG, STEP_ITEM} step_kind_t;

  typedef struct packed {
    step_kind_t   kind;
    logic [8:0]   vcount;
    search_item_t item;
    bit           typed;
    cut_result_t  exp;
  } dir_step_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       cfg_wr_en   = 1'b0;
  logic [MCUT_VCOUNT_W-1:0]   cfg_wr_data = '0;
  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  // row_vertex[7:0], col_vertex[15:8], edge_weight[31:16], side_in[32], zero fill
  logic [MCUT_IN_DATA_W-1:0]  in_tdata    = '0;
  // func[1:0]
  logic [1:0]                 in_tuser    = '0;
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  // side_out[0], cut_value[32:1], sweep_count[48:33], zero fill
  logic [MCUT_OUT_DATA_W-1:0] out_tdata;

  // Predictor state
  shortint     pr_weight [NV][NV];
  bit          pr_side   [NV];
  logic [31:0] pr_cut    = '0;
  logic [15:0] pr_sweeps = '0;
  logic [8:0]  pr_vcount = MCUT_VCOUNT_RESET;

  cut_result_t pending_cuts [$];
  dir_step_t   steps        [$];
  int          errors       = 0;
  int          random_items = 0;
  int          stall_left   = 0;
  int          quiet_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          calm         = 1'b0;

  always #4 clk = ~clk;

  maxcut_one_flip_local_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Apply one transaction to the predictor and return the result it causes
  function automatic cut_result_t predict_cut(search_item_t it);
    int          n, i, j, v, u, passes;
    longint      cut, gain;
    bit          changed;
    cut_result_t res;
    res.side = 1'b0;
    case (it.func)
      FUNC_WR_WEIGHT: begin
        pr_weight[it.row_v][it.col_v] = shortint'(it.weight);
        pr_weight[it.col_v][it.row_v] = shortint'(it.weight);
      end
      FUNC_WR_SIDE: begin
        pr_side[it.row_v] = it.side;
      end
      FUNC_RUN: begin
        n = (pr_vcount == 0) ? 1 : (pr_vcount > NV) ? NV : int'(pr_vcount);
        // cut over upper-triangle pairs on opposite sides
        cut = 0;
        for (i = 0; i < n; i++)
          for (j = i + 1; j < n; j++)
            if (pr_side[i] != pr_side[j]) cut += pr_weight[i][j];
        // sweep until a whole pass flips nothing; the quiet pass counts too
        passes = 0;
        do begin
          changed = 1'b0;
          for (v = 0; v < n; v++) begin
            gain = 0;
            for (u = 0; u < n; u++) begin
              if (u != v) begin
                if (pr_side[u] == pr_side[v]) gain += pr_weight[v][u];
                else gain -= pr_weight[v][u];
              end
            end
            if (gain > 0) begin
              pr_side[v] = !pr_side[v];
              cut += gain;
              changed = 1'b1;
            end
          end
          if (passes < 65535) passes++;
        end while (changed);
        pr_cut    = cut[31:0];
        pr_sweeps = passes[15:0];
      end
      default: begin
        res.side = pr_side[it.row_v];
      end
    endcase
    res.cut    = pr_cut;
    res.sweeps = pr_sweeps;
    return res;
  endfunction

  function automatic search_item_t mk_item(mcut_func_e_t f, logic [7:0] r, logic [7:0] c,
                                           logic [15:0] w, logic s);
    search_item_t it;
    it.func   = f;
    it.row_v  = r;
    it.col_v  = c;
    it.weight = w;
    it.side   = s;
    return it;
  endfunction

  function automatic dir_step_t item_step(search_item_t it, bit typed = 1'b0,
                                          cut_result_t exp = '0);
    dir_step_t st;
    st.kind   = STEP_ITEM;
    st.vcount = '0;
    st.item   = it;
    st.typed  = typed;
    st.exp    = exp;
    return st;
  endfunction

  function automatic dir_step_t cfg_step(logic [8:0] v);
    dir_step_t st;
    st        = '0;
    st.kind   = STEP_CFG;
    st.vcount = v;
    return st;
  endfunction

  // Append one row to the directed table
  task automatic add_step(dir_step_t st);
    steps.insert(steps.size(), st);
  endtask

  // Mostly a vertex in the active range, sometimes any index
  function automatic logic [7:0] pick_vertex(int n);
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
    errors++;
    $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, seen, wanted);
  endtask

  // Drive one transaction from a falling edge, hold until accepted, return at
  // the next falling edge with valid still up
  task automatic send_item(search_item_t it, bit typed = 1'b0, cut_result_t exp = '0);
    cut_result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {7'd0, it.side, it.weight, it.col_v, it.row_v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = predict_cut(it);
    pending_cuts.insert(pending_cuts.size(), typed ? exp : res);
    @(negedge clk);
  endtask

  // Write the vertex count once every outstanding result has come back
  task automatic write_vertex_count(logic [8:0] v);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_cuts.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    pr_vcount = v;
  endtask

  // Result side ready: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    cut_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.side   = out_tdata[0];
      got.cut    = out_tdata[32:1];
      got.sweeps = out_tdata[48:33];
      if (pending_cuts.size() == 0) begin
        report_mismatch("result with nothing pending, cut", got.cut, 32'd0);
      end else begin
        want = pending_cuts.pop_front();
        if (got.side != want.side)
          report_mismatch("side_out", 32'(got.side), 32'(want.side));
        if (got.cut != want.cut) report_mismatch("cut_value", got.cut, want.cut);
        if (got.sweeps != want.sweeps)
          report_mismatch("sweep_count", 32'(got.sweeps), 32'(want.sweeps));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int           i, j, k, cnt, n_eff;
    logic [8:0]   vc;
    mcut_func_e_t f;

    // Directed table; typed expectations only where obvious from reset state
    add_step(item_step(mk_item(FUNC_WR_SIDE, 8'd0, 8'd0, 16'h0, 1'b1), 1'b1,
                       {1'b0, 32'd0, 16'd0}));
    add_step(item_step(mk_item(FUNC_WR_SIDE, 8'd1, 8'd0, 16'h0, 1'b0), 1'b1,
                       {1'b0, 32'd0, 16'd0}));
    add_step(item_step(mk_item(FUNC_RD_SIDE, 8'd0, 8'd0, 16'h0, 1'b0), 1'b1,
                       {1'b1, 32'd0, 16'd0}));
    add_step(item_step(mk_item(FUNC_RD_SIDE, 8'd1, 8'hFF, 16'hFFFF, 1'b1), 1'b1,
                       {1'b0, 32'd0, 16'd0}));
    add_step(item_step(mk_item(FUNC_WR_WEIGHT, 8'd0, 8'd1, 16'h7FFF, 1'b0), 1'b1,
                       {1'b0, 32'd0, 16'd0}));
    // diagonal weight is stored but never counted
    add_step(item_step(mk_item(FUNC_WR_WEIGHT, 8'd1, 8'd1, 16'h8000, 1'b1), 1'b1,
                       {1'b0, 32'd0, 16'd0}));
    add_step(cfg_step(9'd2));
    add_step(item_step(mk_item(FUNC_RUN, 8'd0, 8'd0, 16'h0, 1'b0), 1'b1,
                       {1'b0, 32'd32767, 16'd1}));
    add_step(item_step(mk_item(FUNC_WR_WEIGHT, 8'd1, 8'd0, 16'h8000, 1'b0), 1'b1,
                       {1'b0, 32'd32767, 16'd1}));
    add_step(item_step(mk_item(FUNC_RUN, 8'hFF, 8'hFF, 16'hFFFF, 1'b1)));
    add_step(item_step(mk_item(FUNC_RD_SIDE, 8'd0, 8'd0, 16'h0, 1'b0)));
    // a count of one, and zero acting as one
    add_step(cfg_step(9'd1));
    add_step(item_step(mk_item(FUNC_RUN, 8'd0, 8'd0, 16'h0, 1'b0)));
    add_step(cfg_step(9'd0));
    add_step(item_step(mk_item(FUNC_RUN, 8'd0, 8'd0, 16'h0, 1'b0)));
    add_step(item_step(mk_item(FUNC_WR_SIDE, 8'd2, 8'd0, 16'h0, 1'b1)));
    add_step(item_step(mk_item(FUNC_WR_WEIGHT, 8'd0, 8'd2, 16'hFFFF, 1'b0)));
    add_step(item_step(mk_item(FUNC_WR_WEIGHT, 8'd2, 8'd1, 16'h1234, 1'b0)));
    add_step(cfg_step(9'd3));
    add_step(item_step(mk_item(FUNC_RUN, 8'd0, 8'd0, 16'h0, 1'b0)));
    add_step(item_step(mk_item(FUNC_RD_SIDE, 8'd2, 8'd0, 16'h0, 1'b0)));
    add_step(item_step(mk_item(FUNC_RD_SIDE, 8'd1, 8'd0, 16'h0, 1'b0)));
    // top index, including a diagonal write there
    add_step(item_step(mk_item(FUNC_WR_SIDE, 8'hFF, 8'd0, 16'h0, 1'b1)));
    add_step(item_step(mk_item(FUNC_RD_SIDE, 8'hFF, 8'd0, 16'h0, 1'b0)));
    add_step(item_step(mk_item(FUNC_WR_WEIGHT, 8'hFF, 8'hFF, 16'h7FFF, 1'b0)));

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[s]) begin
      if (steps[s].kind == STEP_CFG) write_vertex_count(steps[s].vcount);
      else send_item(steps[s].item, steps[s].typed, steps[s].exp);
    end

    // Preload: every side bit, and every pair among the first vertices
    idle_on = 1'b0;
    write_vertex_count(9'(PRELOAD_N));
    for (i = 0; i < NV; i++)
      send_item(mk_item(FUNC_WR_SIDE, 8'(i), 8'($urandom), 16'h0, 1'($urandom)));
    for (i = 0; i < PRELOAD_N; i++)
      for (j = i + 1; j < PRELOAD_N; j++)
        if ($urandom_range(0, 1) == 0)
          send_item(mk_item(FUNC_WR_WEIGHT, 8'(i), 8'(j), pick_weight(), 1'b0));
        else
          send_item(mk_item(FUNC_WR_WEIGHT, 8'(j), 8'(i), pick_weight(), 1'b1));
    idle_on = 1'b1;
    send_item(mk_item(FUNC_RUN, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom)));
    repeat (4)
      send_item(mk_item(FUNC_RD_SIDE, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0));

    // Random phases: load, search, read back, with some noise mixed in
    while (random_items < RANDOM_ITEMS) begin
      calm    = (random_items >= CALM_FROM);
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19)) inside
        0:       vc = 9'd0;
        1:       vc = 9'd1;
        2, 3:    vc = 9'($urandom_range(13, PRELOAD_N));
        default: vc = 9'($urandom_range(2, 12));
      endcase
      write_vertex_count(vc);
      n_eff = (vc == 0) ? 1 : int'(vc);
      cnt   = $urandom_range(4, 16);
      for (k = 0; k < cnt; k++) begin
        if (k == cnt - 2) f = FUNC_RUN;
        else if (k == cnt - 1) f = FUNC_RD_SIDE;
        else f = ($urandom_range(0, 2) != 0) ? FUNC_WR_WEIGHT : FUNC_WR_SIDE;
        if ($urandom_range(0, 7) == 0) f = mcut_func_e_t'($urandom_range(0, 3));
        send_item(mk_item(f, pick_vertex(n_eff), pick_vertex(n_eff), pick_weight(),
                          1'($urandom)));
        random_items++;
      end
    end

    // Drain and finish
    calm    = 1'b1;
    idle_on = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_cuts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mcut_pkg.sv
rtl/core/mcut_ram.sv
rtl/core/mcut_gain_unit.sv
rtl/core/maxcut_one_flip_local_search.sv
bench/maxcut_one_flip_local_search_tb.sv
